[rtl/bgps_pkg.sv]
// ----------------------------------------------------------------------------
// bgps_pkg: battery gauge and power state shared definitions
// Field widths, fixed-point constants, reciprocal divide constants, the
// raised-cosine curve rom and the types passed between the pipeline parts.
// ----------------------------------------------------------------------------
package bgps_pkg;

  // curve rom resolution and index widths
  localparam int CURVE_ENTRIES = 256;
  localparam int IDX_W         = $clog2(CURVE_ENTRIES);
  localparam int ROM_IDX_W     = $clog2(CURVE_ENTRIES + 1);

  // field widths
  localparam int CODE_W     = 12;
  localparam int MV_W       = 13;
  localparam int LEVEL_W    = 17;
  localparam int MODE_W     = 2;
  localparam int CLKREQ_W   = 2;
  localparam int FULL_LEVEL = 65536;

  // voltage held as code * 4389 in 1/4096 mV units
  localparam int FRAC_BITS  = 12;
  localparam int VOLT_SCALE = 4389;
  localparam int VOLT_W     = $clog2(((1 << CODE_W) - 1) * VOLT_SCALE
                                     + (1 << (FRAC_BITS - 1)) + 1);
  localparam int LOW_MV     = 3300;
  localparam int HIGH_MV    = 3800;
  localparam int SPAN_MV    = HIGH_MV - LOW_MV;
  localparam int V_LOW      = LOW_MV << FRAC_BITS;
  localparam int V_HIGH     = HIGH_MV << FRAC_BITS;
  localparam int V_SPAN     = SPAN_MV << FRAC_BITS;
  localparam int DELTA_W    = $clog2(V_SPAN);

  // scaled position p = delta * entries, and its upper part for the divide
  localparam int Q_W   = $clog2(longint'(V_SPAN) * CURVE_ENTRIES);
  localparam int QHI_W = Q_W - FRAC_BITS;

  // exact divide by the span in mV: floor(x * rcp >> sh), rcp rounded up
  localparam int      K_SH    = QHI_W + $clog2(SPAN_MV);
  localparam int      K_RCP_W = QHI_W + 1;
  localparam longint  K_RCP   = ((longint'(1) << K_SH) + SPAN_MV - 1) / SPAN_MV;
  localparam int      KF_W    = QHI_W + K_RCP_W - K_SH;

  // interpolation: product of slope and remainder, then divide by the span
  localparam int      PROD_W  = LEVEL_W + DELTA_W;
  localparam int      FX_W    = $clog2(FULL_LEVEL * SPAN_MV);
  localparam int      F_SH    = FX_W + $clog2(SPAN_MV);
  localparam int      F_RCP_W = FX_W + 1;
  localparam longint  F_RCP   = ((longint'(1) << F_SH) + SPAN_MV - 1) / SPAN_MV;

  // exponential average: (19 * level + raw + 10) / 20
  localparam int      AVG_KEEP  = 19;
  localparam int      AVG_DIV   = 20;
  localparam int      AVG_ROUND = 10;
  localparam int      AVG_W     = $clog2(AVG_DIV * FULL_LEVEL + AVG_ROUND + 1);
  localparam int      AVG_SH    = AVG_W + $clog2(AVG_DIV);
  localparam int      AVG_RCP_W = AVG_W + 1;
  localparam longint  AVG_RCP   = ((longint'(1) << AVG_SH) + AVG_DIV - 1) / AVG_DIV;

  // power saving threshold after reset
  localparam logic [LEVEL_W-1:0] SAVING_LEVEL_RST = LEVEL_W'(13107);

  // power mode and clock request codes
  typedef enum logic [MODE_W-1:0] {
    MODE_CHARGING    = 2'd0,
    MODE_DISCHARGING = 2'd1,
    MODE_SAVING      = 2'd2
  } power_mode_t;

  typedef enum logic [CLKREQ_W-1:0] {
    CLK_KEEP = 2'd0,
    CLK_FAST = 2'd1,
    CLK_SLOW = 2'd2
  } clock_req_t;

  // sample side info carried along the pipeline
  typedef struct packed {
    logic              charger;
    logic              below;
    logic              above;
    logic [MV_W-1:0]   mv;
  } tag_t;

  // beat from the voltage stage to the curve stage
  typedef struct packed {
    tag_t              tag;
    logic [Q_W-1:0]    q;
  } volt_t;

  // beat from the curve stage to the averaging stage
  typedef struct packed {
    logic                charger;
    logic [MV_W-1:0]     mv;
    logic [LEVEL_W-1:0]  raw;
  } raw_t;

  // raised-cosine curve rom, built at elaboration
  typedef logic [LEVEL_W-1:0] level_t;
  typedef level_t [CURVE_ENTRIES:0] curve_rom_t;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;
  localparam longint unsigned TAYLOR_DIV [1:7] = '{6, 20, 42, 72, 110, 156, 210};

  // q30 sine by taylor series with truncating products
  function automatic longint unsigned sine_q30(input longint unsigned a);
    longint unsigned term;
    longint          s;
    term = a;
    s    = longint'(a);
    for (int n = 1; n <= 7; n++) begin
      term = (term * a) >> 30;
      term = (term * a) >> 30;
      term = term / TAYLOR_DIV[n];
      if ((n & 1) != 0) begin
        s = s - longint'(term);
      end else begin
        s = s + longint'(term);
      end
    end
    if (s < 0) begin
      s = 0;
    end
    if (s > longint'(ONE_Q30)) begin
      s = longint'(ONE_Q30);
    end
    return longint'(s);
  endfunction

  // entry k = round(65536 * sin^2(pi * k / (2 * entries)))
  function automatic curve_rom_t build_curve();
    curve_rom_t      rom;
    longint unsigned a;
    longint unsigned s;
    longint unsigned e;
    for (int k = 0; k <= CURVE_ENTRIES; k++) begin
      a = HALF_PI_Q30 * longint'(k) / CURVE_ENTRIES;
      s = sine_q30(a);
      e = (s * s + (64'd1 << 43)) >> 44;
      if (e > FULL_LEVEL) begin
        e = FULL_LEVEL;
      end
      rom[k] = LEVEL_W'(e);
    end
    return rom;
  endfunction

  localparam curve_rom_t CURVE_ROM = build_curve();

endpackage

[rtl/bgps_if.sv]
// ----------------------------------------------------------------------------
// bgps_if: sample and result channels
// Valid/ready channels for battery samples in and gauge results out.
// ----------------------------------------------------------------------------
interface bgps_in_if import bgps_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] adc_code;
  logic              charger_present;

  modport source (output valid, output adc_code, output charger_present, input ready);
  modport sink   (input valid, input adc_code, input charger_present, output ready);
endinterface

interface bgps_out_if import bgps_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MV_W-1:0]     battery_millivolts;
  logic [LEVEL_W-1:0]  battery_level;
  logic [MODE_W-1:0]   power_mode;
  logic [CLKREQ_W-1:0] clock_request;

  modport source (output valid, output battery_millivolts, output battery_level,
                  output power_mode, output clock_request, input ready);
  modport sink   (input valid, input battery_millivolts, input battery_level,
                  input power_mode, input clock_request, output ready);
endinterface

[rtl/bgps_volt.sv]
// ----------------------------------------------------------------------------
// bgps_volt: sample register, voltage scaling and range classification
// Three stages: sample register, code * 4389 product, then millivolt
// rounding, threshold compares and the scaled curve position.
// ----------------------------------------------------------------------------
module bgps_volt import bgps_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] in_code,
  input  logic              in_charger,
  output logic              out_valid,
  input  logic              out_ready,
  output volt_t             out_data
);

  logic              smp_vld_r, mul_vld_r, cls_vld_r;
  logic              smp_rdy, mul_rdy, cls_rdy;
  logic [CODE_W-1:0] code_r;
  logic              chg_smp_r, chg_mul_r;
  logic [VOLT_W-1:0] volt_r, volt_nxt, volt_rnd;
  logic [DELTA_W-1:0] delta;
  volt_t             cls_r, cls_nxt;

  // stage ready chain
  assign cls_rdy  = !cls_vld_r || out_ready;
  assign mul_rdy  = !mul_vld_r || cls_rdy;
  assign smp_rdy  = !smp_vld_r || mul_rdy;
  assign in_ready = smp_rdy;

  // voltage in 1/4096 mV units
  assign volt_nxt = VOLT_W'(code_r) * VOLT_W'(VOLT_SCALE);

  // millivolts, range flags and position above the low threshold
  always_comb begin
    volt_rnd          = volt_r + VOLT_W'(1 << (FRAC_BITS - 1));
    delta             = DELTA_W'(volt_r - VOLT_W'(V_LOW));
    cls_nxt.tag.charger = chg_mul_r;
    cls_nxt.tag.below   = (volt_r <= VOLT_W'(V_LOW));
    cls_nxt.tag.above   = (volt_r >= VOLT_W'(V_HIGH));
    cls_nxt.tag.mv      = MV_W'(volt_rnd >> FRAC_BITS);
    cls_nxt.q           = Q_W'(delta) * Q_W'(CURVE_ENTRIES);
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
      cls_vld_r <= 1'b0;
    end else begin
      if (smp_rdy) smp_vld_r <= in_valid;
      if (mul_rdy) mul_vld_r <= smp_vld_r;
      if (cls_rdy) cls_vld_r <= mul_vld_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (smp_rdy) begin
      code_r    <= in_code;
      chg_smp_r <= in_charger;
    end
    if (mul_rdy) begin
      volt_r    <= volt_nxt;
      chg_mul_r <= chg_smp_r;
    end
    if (cls_rdy) begin
      cls_r <= cls_nxt;
    end
  end

  assign out_valid = cls_vld_r;
  assign out_data  = cls_r;

  // the two thresholds never both match
  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    cls_vld_r |-> !(cls_r.tag.below && cls_r.tag.above))
    else $error("voltage both below and above thresholds");

endmodule

[rtl/bgps_curve.sv]
// ----------------------------------------------------------------------------
// bgps_curve: curve segment select and linear interpolation
// Four stages: segment index by reciprocal divide, rom read and remainder,
// slope times remainder, then the fractional step and range clamp.
// ----------------------------------------------------------------------------
module bgps_curve import bgps_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  volt_t in_data,
  output logic  out_valid,
  input  logic  out_ready,
  output raw_t  out_data
);

  logic idx_vld_r, rom_vld_r, mul_vld_r, res_vld_r;
  logic idx_rdy, rom_rdy, mul_rdy, res_rdy;

  tag_t idx_tag_r, rom_tag_r, mul_tag_r;
  logic [Q_W-1:0]     idx_q_r;
  logic [IDX_W-1:0]   k_r, k_nxt;
  logic [LEVEL_W-1:0] lo_r, lo_nxt, lo_mul_r, diff_r, diff_nxt;
  logic [DELTA_W-1:0] rem_r, rem_nxt;
  logic [PROD_W-1:0]  prod_r, prod_nxt;
  raw_t               res_r, res_nxt;

  logic [QHI_W-1:0]          q_hi;
  logic [QHI_W+K_RCP_W-1:0]  k_prod;
  logic [KF_W-1:0]           k_full;
  logic [ROM_IDX_W-1:0]      lo_idx, hi_idx;
  logic [LEVEL_W-1:0]        hi_val;
  logic [Q_W-1:0]            k_span;
  logic [FX_W-1:0]           fx;
  logic [FX_W+F_RCP_W-1:0]   f_prod;
  logic [LEVEL_W-1:0]        frac;

  // stage ready chain
  assign res_rdy  = !res_vld_r || out_ready;
  assign mul_rdy  = !mul_vld_r || res_rdy;
  assign rom_rdy  = !rom_vld_r || mul_rdy;
  assign idx_rdy  = !idx_vld_r || rom_rdy;
  assign in_ready = idx_rdy;

  // segment index: floor(q / span), span = 500 * 4096
  always_comb begin
    q_hi   = in_data.q[Q_W-1:FRAC_BITS];
    k_prod = (QHI_W+K_RCP_W)'(q_hi) * (QHI_W+K_RCP_W)'(K_RCP);
    k_full = KF_W'(k_prod >> K_SH);
    if (k_full > KF_W'(CURVE_ENTRIES - 1)) begin
      k_nxt = IDX_W'(CURVE_ENTRIES - 1);
    end else begin
      k_nxt = IDX_W'(k_full);
    end
  end

  // rom pair, slope and remainder within the segment
  always_comb begin
    lo_idx  = ROM_IDX_W'(k_r);
    hi_idx  = lo_idx + ROM_IDX_W'(1);
    lo_nxt  = CURVE_ROM[lo_idx];
    hi_val  = CURVE_ROM[hi_idx];
    if (hi_val > lo_nxt) begin
      diff_nxt = hi_val - lo_nxt;
    end else begin
      diff_nxt = '0;
    end
    k_span  = Q_W'(k_r) * Q_W'(V_SPAN);
    rem_nxt = DELTA_W'(idx_q_r - k_span);
  end

  // slope times remainder
  assign prod_nxt = PROD_W'(diff_r) * PROD_W'(rem_r);

  // fractional step, then the flat regions
  always_comb begin
    fx      = FX_W'(prod_r >> FRAC_BITS);
    f_prod  = (FX_W+F_RCP_W)'(fx) * (FX_W+F_RCP_W)'(F_RCP);
    frac    = LEVEL_W'(f_prod >> F_SH);
    res_nxt.charger = mul_tag_r.charger;
    res_nxt.mv      = mul_tag_r.mv;
    if (mul_tag_r.above) begin
      res_nxt.raw = LEVEL_W'(FULL_LEVEL);
    end else if (mul_tag_r.below) begin
      res_nxt.raw = '0;
    end else begin
      res_nxt.raw = lo_mul_r + frac;
    end
  end

  // stage valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_vld_r <= 1'b0;
      rom_vld_r <= 1'b0;
      mul_vld_r <= 1'b0;
      res_vld_r <= 1'b0;
    end else begin
      if (idx_rdy) idx_vld_r <= in_valid;
      if (rom_rdy) rom_vld_r <= idx_vld_r;
      if (mul_rdy) mul_vld_r <= rom_vld_r;
      if (res_rdy) res_vld_r <= mul_vld_r;
    end
  end

  // stage payload
  always_ff @(posedge clk) begin
    if (idx_rdy) begin
      idx_tag_r <= in_data.tag;
      idx_q_r   <= in_data.q;
      k_r       <= k_nxt;
    end
    if (rom_rdy) begin
      rom_tag_r <= idx_tag_r;
      lo_r      <= lo_nxt;
      diff_r    <= diff_nxt;
      rem_r     <= rem_nxt;
    end
    if (mul_rdy) begin
      mul_tag_r <= rom_tag_r;
      lo_mul_r  <= lo_r;
      prod_r    <= prod_nxt;
    end
    if (res_rdy) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = res_vld_r;
  assign out_data  = res_r;

  // interpolated level stays within full scale
  a_raw_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_vld_r |-> (res_r.raw <= LEVEL_W'(FULL_LEVEL)))
    else $error("raw level above full scale");

endmodule

[rtl/bgps_state.sv]
// ----------------------------------------------------------------------------
// bgps_state: level averaging, power mode and clock request
// Output register stage. The exponential average and the mode register
// close their loop here, updating with each loaded beat.
// ----------------------------------------------------------------------------
module bgps_state import bgps_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [LEVEL_W-1:0]  cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  raw_t                in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [MV_W-1:0]     out_millivolts,
  output logic [LEVEL_W-1:0]  out_level,
  output logic [MODE_W-1:0]   out_mode,
  output logic [CLKREQ_W-1:0] out_clock
);

  logic                      out_vld_r;
  logic                      load;
  logic [LEVEL_W-1:0]        level_r, level_nxt, avg;
  logic [LEVEL_W-1:0]        saving_level_r;
  power_mode_t               mode_r, mode_nxt;
  clock_req_t                clk_r, clk_nxt;
  logic [MV_W-1:0]           mv_r;
  logic [AVG_W-1:0]          acc;
  logic [AVG_W+AVG_RCP_W-1:0] acc_prod;

  // output stage handshake
  assign in_ready = !out_vld_r || out_ready;
  assign load     = in_valid && in_ready;

  // level = (19 * level + raw + 10) / 20
  always_comb begin
    acc      = AVG_W'(level_r) * AVG_W'(AVG_KEEP) + AVG_W'(in_data.raw)
               + AVG_W'(AVG_ROUND);
    acc_prod = (AVG_W+AVG_RCP_W)'(acc) * (AVG_W+AVG_RCP_W)'(AVG_RCP);
    avg      = LEVEL_W'(acc_prod >> AVG_SH);
    if (avg > LEVEL_W'(FULL_LEVEL)) begin
      level_nxt = LEVEL_W'(FULL_LEVEL);
    end else begin
      level_nxt = avg;
    end
  end

  // next power mode
  always_comb begin
    if (in_data.charger) begin
      mode_nxt = MODE_CHARGING;
    end else if (level_nxt > saving_level_r) begin
      mode_nxt = MODE_DISCHARGING;
    end else begin
      mode_nxt = MODE_SAVING;
    end
  end

  // clock request on mode transitions
  always_comb begin
    clk_nxt = CLK_KEEP;
    if (mode_nxt != mode_r) begin
      if (mode_nxt == MODE_CHARGING) begin
        clk_nxt = CLK_SLOW;
      end else if (mode_nxt == MODE_DISCHARGING && mode_r == MODE_CHARGING) begin
        clk_nxt = CLK_FAST;
      end
    end
  end

  // control and state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r      <= 1'b0;
      level_r        <= '0;
      mode_r         <= MODE_DISCHARGING;
      saving_level_r <= SAVING_LEVEL_RST;
    end else begin
      if (in_ready) out_vld_r <= in_valid;
      if (load) begin
        level_r <= level_nxt;
        mode_r  <= mode_nxt;
      end
      if (cfg_we) saving_level_r <= cfg_wdata;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load) begin
      mv_r  <= in_data.mv;
      clk_r <= clk_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_millivolts = mv_r;
  assign out_level      = level_r;
  assign out_mode       = mode_r;
  assign out_clock      = clk_r;

  // slow clock only when entering charging
  a_slow_on_charge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && clk_r == CLK_SLOW) |-> (mode_r == MODE_CHARGING))
    else $error("slow clock request outside charging");

  // fast clock only when dropping into discharging
  a_fast_on_discharge: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && clk_r == CLK_FAST) |-> (mode_r == MODE_DISCHARGING))
    else $error("fast clock request outside discharging");

  // average and mode move only with a loaded beat
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> ($stable(level_r) && $stable(mode_r)))
    else $error("gauge state changed without a beat");

endmodule

[rtl/battery_gauge_power_state.sv]
// ----------------------------------------------------------------------------
// battery_gauge_power_state: battery gauge and power mode selector
// Takes one battery sample per beat and returns one gauge result per beat.
// ----------------------------------------------------------------------------
// Each sample beat (12-bit converter code, charger pin) yields one result
// beat: the battery voltage in millivolts, the smoothed Q16 charge level,
// the power mode and a clock change request. A new sample is taken every
// cycle while the result side does not stall; a result passes through the
// voltage scaling and range check stages, the curve lookup and
// interpolation stages and the output register. The level average and the
// mode register update together in the output stage, so consecutive samples
// never wait on each other. The user must write the power saving threshold
// through cfg_we/cfg_wdata (17-bit Q16, reset 13107) only while no beats are
// in flight; the block itself does not enforce this. The curve is a constant
// rom; there is no start-up sweep after reset.
// ----------------------------------------------------------------------------
module battery_gauge_power_state import bgps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  bgps_in_if.sink            in_chan,
  bgps_out_if.source         out_chan,
  input  logic               cfg_we,
  input  logic [LEVEL_W-1:0] cfg_wdata
);

  logic  volt_vld, volt_rdy;
  volt_t volt_data;
  logic  raw_vld, raw_rdy;
  raw_t  raw_data;

  // voltage scaling and classification
  bgps_volt u_volt (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_chan.valid),
    .in_ready   (in_chan.ready),
    .in_code    (in_chan.adc_code),
    .in_charger (in_chan.charger_present),
    .out_valid  (volt_vld),
    .out_ready  (volt_rdy),
    .out_data   (volt_data)
  );

  // curve lookup and interpolation
  bgps_curve u_curve (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (volt_vld),
    .in_ready  (volt_rdy),
    .in_data   (volt_data),
    .out_valid (raw_vld),
    .out_ready (raw_rdy),
    .out_data  (raw_data)
  );

  // averaging, mode and clock request
  bgps_state u_state (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (raw_vld),
    .in_ready       (raw_rdy),
    .in_data        (raw_data),
    .out_valid      (out_chan.valid),
    .out_ready      (out_chan.ready),
    .out_millivolts (out_chan.battery_millivolts),
    .out_level      (out_chan.battery_level),
    .out_mode       (out_chan.power_mode),
    .out_clock      (out_chan.clock_request)
  );

endmodule

[tb/tb_battery_gauge_power_state.sv]
// ----------------------------------------------------------------------------
// tb_battery_gauge_power_state: self-checking bench for the battery gauge
// Drives battery sample beats through the valid/ready input channel and
// checks every result beat against an in-bench gauge predictor: millivolt
// scaling, curve lookup with interpolation, level smoothing, mode choice and
// clock requests. Corner samples and mode transitions come first, then
// random charge, drain and curve runs under several idle patterns and
// power saving thresholds.
// ----------------------------------------------------------------------------
module tb_battery_gauge_power_state import bgps_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  // voltage thresholds in 1/4096 mV units
  localparam longint unsigned VOLT_EMPTY = 64'd3300 * 64'd4096;
  localparam longint unsigned VOLT_FULL  = 64'd3800 * 64'd4096;
  localparam longint unsigned VOLT_RANGE = 64'd500 * 64'd4096;
  localparam longint unsigned QUARTER_TURN_Q30 = 64'd1686629713;
  localparam longint unsigned UNIT_Q30 = 64'd1 << 30;
  localparam int unsigned LEVEL_FULL = 65536;

  // converter codes at the edges of the curve region
  localparam logic [CODE_W-1:0] CODE_BELOW_CURVE = 12'd3079;
  localparam logic [CODE_W-1:0] CODE_CURVE_FIRST = 12'd3080;
  localparam logic [CODE_W-1:0] CODE_CURVE_LAST  = 12'd3546;
  localparam logic [CODE_W-1:0] CODE_ABOVE_CURVE = 12'd3547;
  localparam logic [CODE_W-1:0] CODE_MAX         = 12'd4095;

  typedef struct {
    logic [MV_W-1:0]    mv;
    logic [LEVEL_W-1:0] level;
    power_mode_t        mode;
    clock_req_t         clkreq;
  } gauge_result_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [LEVEL_W-1:0] cfg_wdata;

  bgps_in_if  in_if ();
  bgps_out_if out_if ();

  battery_gauge_power_state u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_if),
    .out_chan  (out_if),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  // predictor state
  int unsigned        curve_tbl [0:CURVE_ENTRIES];
  logic [LEVEL_W-1:0] level_state;
  power_mode_t        mode_state;
  logic [LEVEL_W-1:0] saving_level;

  gauge_result_t pending_gauge_q [$];
  int            mismatch_count;
  int            send_idle_pct;
  int            recv_idle_pct;

  initial clk = 1'b0;
  always #4 clk = ~clk;

  // q30 sine, taylor series with truncating products
  function automatic longint unsigned q30_sine(input longint unsigned ang);
    longint unsigned pw;
    longint          acc;
    pw  = ang;
    acc = longint'(ang);
    for (int n = 1; n <= 7; n++) begin
      pw = (pw * ang) >> 30;
      pw = (pw * ang) >> 30;
      pw = pw / longint'((2 * n) * (2 * n + 1));
      if (n % 2 == 1) begin
        acc = acc - longint'(pw);
      end else begin
        acc = acc + longint'(pw);
      end
    end
    if (acc < 0) begin
      acc = 0;
    end
    if (acc > longint'(UNIT_Q30)) begin
      acc = longint'(UNIT_Q30);
    end
    return longint'(acc);
  endfunction

  // raised-cosine table, squared sine rounded to q16
  function automatic void fill_curve_tbl();
    longint unsigned sn;
    longint unsigned sq;
    for (int k = 0; k <= CURVE_ENTRIES; k++) begin
      sn = q30_sine(QUARTER_TURN_Q30 * longint'(k) / CURVE_ENTRIES);
      sq = (sn * sn + (64'd1 << 43)) >> 44;
      curve_tbl[k] = (sq > LEVEL_FULL) ? LEVEL_FULL : int'(sq);
    end
  endfunction

  // expected result for one sample, advances level and mode
  function automatic gauge_result_t gauge_for_sample(input logic [CODE_W-1:0] code,
                                                     input logic chg);
    gauge_result_t   res;
    longint unsigned volt;
    longint unsigned pos;
    longint unsigned seg;
    longint unsigned rem;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned raw;
    longint unsigned avg;
    power_mode_t     next_mode;
    volt   = longint'(code) * 64'd4389;
    res.mv = MV_W'((volt + 64'd2048) >> 12);
    // raw level from voltage
    if (volt >= VOLT_FULL) begin
      raw = LEVEL_FULL;
    end else if (volt <= VOLT_EMPTY) begin
      raw = 0;
    end else begin
      pos = (volt - VOLT_EMPTY) * CURVE_ENTRIES;
      seg = pos / VOLT_RANGE;
      rem = pos % VOLT_RANGE;
      if (seg >= CURVE_ENTRIES) begin
        seg = CURVE_ENTRIES - 1;
      end
      lo = curve_tbl[int'(seg)];
      hi = curve_tbl[int'(seg) + 1];
      if (hi < lo) begin
        hi = lo;
      end
      raw = lo + (hi - lo) * rem / VOLT_RANGE;
    end
    // exponential average
    avg = (longint'(level_state) * 19 + raw + 10) / 20;
    if (avg > LEVEL_FULL) begin
      avg = LEVEL_FULL;
    end
    level_state = LEVEL_W'(avg);
    // mode and clock request
    if (chg) begin
      next_mode = MODE_CHARGING;
    end else if (level_state > saving_level) begin
      next_mode = MODE_DISCHARGING;
    end else begin
      next_mode = MODE_SAVING;
    end
    res.clkreq = CLK_KEEP;
    if (next_mode != mode_state) begin
      if (next_mode == MODE_CHARGING) begin
        res.clkreq = CLK_SLOW;
      end else if (next_mode == MODE_DISCHARGING && mode_state == MODE_CHARGING) begin
        res.clkreq = CLK_FAST;
      end
    end
    mode_state = next_mode;
    res.level  = level_state;
    res.mode   = next_mode;
    return res;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // result side: check each accepted beat, then pick next ready
  always @(posedge clk) begin
    gauge_result_t want;
    if (out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_gauge_q.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result beat, mv %0d level %0d mode %0d clk %0d", $time,
                 out_if.battery_millivolts, out_if.battery_level, out_if.power_mode,
                 out_if.clock_request);
      end else begin
        want = pending_gauge_q.pop_front();
        check_field("battery_millivolts", want.mv, out_if.battery_millivolts);
        check_field("battery_level", want.level, out_if.battery_level);
        check_field("power_mode", int'(want.mode), out_if.power_mode);
        check_field("clock_request", int'(want.clkreq), out_if.clock_request);
      end
    end
    out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // one sample beat; valid stays high on return for back-to-back beats
  task automatic send_sample(input logic [CODE_W-1:0] code, input logic chg);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk);
    end
    in_if.valid           <= 1'b1;
    in_if.adc_code        <= code;
    in_if.charger_present <= chg;
    @(posedge clk);
    while (in_if.ready !== 1'b1) begin
      @(posedge clk);
    end
    pending_gauge_q.push_back(gauge_for_sample(code, chg));
  endtask

  // stop sending and wait for all results
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do begin
      @(posedge clk);
    end while (pending_gauge_q.size() != 0);
  endtask

  task automatic write_saving_level(input logic [LEVEL_W-1:0] value);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we       <= 1'b0;
    saving_level = value;
  endtask

  // voltage range edges and field extremes at the reset threshold
  task automatic test_range_edges();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    send_sample(12'd0, 1'b0);
    send_sample(CODE_MAX, 1'b0);
    send_sample(CODE_BELOW_CURVE, 1'b0);
    send_sample(CODE_CURVE_FIRST, 1'b0);
    send_sample(12'd3313, 1'b0);
    send_sample(CODE_CURVE_LAST, 1'b0);
    send_sample(CODE_ABOVE_CURVE, 1'b0);
    send_sample(CODE_MAX, 1'b1);
    send_sample(12'h555, 1'b1);
    send_sample(12'd0, 1'b0);
    send_sample(CODE_MAX, 1'b1);
    send_sample(12'hAAA, 1'b0);
    drain_results();
  endtask

  // every clock request, zero threshold and the wide register
  task automatic test_mode_transitions();
    write_saving_level('0);
    send_sample(CODE_MAX, 1'b1);
    send_sample(CODE_MAX, 1'b0);
    send_sample(CODE_MAX, 1'b0);
    send_sample(12'd0, 1'b1);
    send_sample(12'd0, 1'b0);
    write_saving_level('1);
    send_sample(CODE_MAX, 1'b0);
    send_sample(CODE_MAX, 1'b1);
    send_sample(CODE_MAX, 1'b0);
    write_saving_level(LEVEL_W'(LEVEL_FULL));
    send_sample(CODE_MAX, 1'b0);
    send_sample(CODE_MAX, 1'b1);
    send_sample(CODE_MAX, 1'b0);
    drain_results();
  endtask

  // runs of charge, drain and curve samples with some noise beats
  task automatic test_random_traffic(input int items, input int s_pct, input int r_pct,
                                     input logic [LEVEL_W-1:0] threshold);
    int               sent;
    int               run_len;
    int               band;
    logic             chg;
    logic [CODE_W-1:0] code;
    write_saving_level(threshold);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 15) begin
        send_sample(CODE_W'($urandom), 1'($urandom));
        sent++;
      end else begin
        run_len = $urandom_range(60, 10);
        band    = $urandom_range(2, 0);
        chg     = ($urandom_range(99) < 30);
        for (int i = 0; i < run_len; i++) begin
          case (band)
            0: code = CODE_W'($urandom_range(CODE_BELOW_CURVE, 0));
            1: code = CODE_W'($urandom_range(CODE_CURVE_LAST, CODE_CURVE_FIRST));
            default: code = CODE_W'($urandom_range(CODE_MAX, CODE_ABOVE_CURVE));
          endcase
          if ($urandom_range(99) < 8) begin
            chg = ~chg;
          end
          send_sample(code, chg);
          sent++;
        end
      end
    end
    drain_results();
  endtask

  initial begin
    fill_curve_tbl();
    level_state    = '0;
    mode_state     = MODE_DISCHARGING;
    saving_level   = SAVING_LEVEL_RST;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_idle_pct  = 0;
    rst_n                 <= 1'b0;
    cfg_we                <= 1'b0;
    cfg_wdata             <= '0;
    in_if.valid           <= 1'b0;
    in_if.adc_code        <= '0;
    in_if.charger_present <= 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_range_edges();
    test_mode_transitions();
    test_random_traffic(270, 24, 59, LEVEL_W'($urandom_range(40000, 6000)));
    test_random_traffic(270, 59, 24, LEVEL_W'(LEVEL_FULL));
    test_random_traffic(270, 0, 0, LEVEL_W'($urandom_range(60000, 2000)));

    drain_results();
    repeat (16) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[battery_gauge_power_state] OK");
    end else begin
      $display("[battery_gauge_power_state] ERROR");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[battery_gauge_power_state] ERROR");
    $finish;
  end

endmodule
